@@ hw/rtl/sorted_id_offset_lookup_defines.svh @@
// Assertion macros shared by the lookup block.
// Each macro takes a label, the clock, the reset, and the property terms.
`ifndef SORTED_ID_OFFSET_LOOKUP_DEFINES_SVH
`define SORTED_ID_OFFSET_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/sool_pkg.sv @@
`timescale 1ns / 1ps

package sool_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int IDX_W       = CNT_W + 1;
   localparam int NUM_TYPES   = 8;

   // Field widths.
   localparam int OPC_W  = 2;
   localparam int TYPE_W = 3;
   localparam int ID_W   = 64;
   localparam int OFS_W  = 48;
   localparam int STAT_W = 3;

   // Command queue between the front and the back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [TYPE_W:0]  NUM_TYPES_W = (TYPE_W + 1)'(NUM_TYPES);
   localparam logic [CNT_W-1:0] TOTAL_MAX   = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W:0]   POS_LIMIT   = (CNT_W + 1)'(TABLE_DEPTH);

   typedef enum logic [OPC_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE      = 3'd0,
      STAT_FOUND     = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_ORDER     = 3'd4
   } status_type;

   // One classified command as it sits in the queue.
   typedef struct packed {
      opcode_type              kind;
      logic                    type_ok;
      logic [TYPE_W-1:0]       etype;
      logic signed [ID_W-1:0]  id;
      logic [OFS_W-1:0]        offset;
   } cmd_type;

endpackage

@@ hw/rtl/sorted_id_offset_lookup.sv @@
`timescale 1ns / 1ps
// Clear, load and unused opcodes finish once the back takes them; a lookup of type t first
// walks the counts of the types below t, then probes with one RAM read and compare each,
// with at most 13 probes over 4096 entries.
// Throughput: one clear or load per cycle while each result is popped; a lookup holds the back
// until its search ends while the 2-entry queue keeps accepting.
// Reset clears the counts, last type, queue and result slot; the tables are not swept.

module sorted_id_offset_lookup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [sool_pkg::OPC_W-1:0]          req_opcode,
   input  logic [sool_pkg::TYPE_W-1:0]         req_entry_type,
   input  logic signed [sool_pkg::ID_W-1:0]    req_entry_id,
   input  logic [sool_pkg::OFS_W-1:0]          req_entry_offset,
   output logic                                empty,
   input  logic                                pop,
   output logic [sool_pkg::STAT_W-1:0]         rsp_status,
   output logic [sool_pkg::OFS_W-1:0]          rsp_found_offset
);

   // The front takes each word, decodes its opcode, checks that its type is
   // in range, and parks it in a short command queue. Because the queue sits
   // between the two halves, new words are taken while a search is running
   // or while a finished result waits to be popped, until the queue is full.
   logic              cmd_valid;
   logic              cmd_pop;
   sool_pkg::cmd_type cmd;

   sool_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_entry_type   (req_entry_type),
      .req_entry_id     (req_entry_id),
      .req_entry_offset (req_entry_offset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // The back owns all table state. It takes a command only when its result
   // slot is free (or being popped in the same cycle). Clear and load finish
   // without leaving the idle state. A lookup first walks the per-type counts to find the base
   // of the type's region, then runs a binary search with one RAM read and
   // one signed compare per probe. An empty or exhausted region reports not
   // found with a zero offset.
   sool_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_found_offset (rsp_found_offset)
   );

endmodule

@@ hw/rtl/sool_ram.sv @@
`timescale 1ns / 1ps

module sool_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/sool_front.sv @@
`timescale 1ns / 1ps
`include "sorted_id_offset_lookup_defines.svh"

module sool_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [sool_pkg::OPC_W-1:0]          req_opcode,
   input  logic [sool_pkg::TYPE_W-1:0]         req_entry_type,
   input  logic signed [sool_pkg::ID_W-1:0]    req_entry_id,
   input  logic [sool_pkg::OFS_W-1:0]          req_entry_offset,
   output logic                                cmd_valid,
   output sool_pkg::cmd_type                   cmd,
   input  logic                                cmd_pop
);

   sool_pkg::cmd_type q_ff [sool_pkg::QDEPTH];
   logic [sool_pkg::QPTR_W-1:0] wptr_ff, wptr_in;
   logic [sool_pkg::QPTR_W-1:0] rptr_ff, rptr_in;
   logic [sool_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   sool_pkg::cmd_type           cls;
   logic                        accept;

   // Classify the incoming word.
   always_comb begin
      cls.etype   = req_entry_type;
      cls.id      = req_entry_id;
      cls.offset  = req_entry_offset;
      cls.type_ok = ({1'b0, req_entry_type} < sool_pkg::NUM_TYPES_W);
      case (req_opcode)
         sool_pkg::OP_CLEAR:  cls.kind = sool_pkg::OP_CLEAR;
         sool_pkg::OP_LOAD:   cls.kind = sool_pkg::OP_LOAD;
         sool_pkg::OP_LOOKUP: cls.kind = sool_pkg::OP_LOOKUP;
         default:             cls.kind = sool_pkg::OP_NONE;
      endcase
   end

   assign full      = (cnt_ff == sool_pkg::QCNT_W'(sool_pkg::QDEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         wptr_in = (wptr_ff == sool_pkg::QPTR_W'(sool_pkg::QDEPTH - 1)) ? '0
                   : wptr_ff + sool_pkg::QPTR_W'(1);
      end
      if (cmd_pop) begin
         rptr_in = (rptr_ff == sool_pkg::QPTR_W'(sool_pkg::QDEPTH - 1)) ? '0
                   : rptr_ff + sool_pkg::QPTR_W'(1);
      end
      if (accept && !cmd_pop) begin
         cnt_in = cnt_ff + sool_pkg::QCNT_W'(1);
      end else if (!accept && cmd_pop) begin
         cnt_in = cnt_ff - sool_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wptr_ff] <= cls;
      end
   end

   `ASSERT_IMPLY(a_pop_needs_entry, clock, reset, cmd_pop, cnt_ff != '0)
   `ASSERT_NEXT(a_push_grows_queue, clock, reset, accept && !cmd_pop, cnt_ff > $past(cnt_ff))
   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, cnt_ff <= sool_pkg::QCNT_W'(sool_pkg::QDEPTH))

endmodule

@@ hw/rtl/sool_back.sv @@
`timescale 1ns / 1ps
`include "sorted_id_offset_lookup_defines.svh"

module sool_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  sool_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          empty,
   input  logic                          pop,
   output logic [sool_pkg::STAT_W-1:0]   rsp_status,
   output logic [sool_pkg::OFS_W-1:0]    rsp_found_offset
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BASE  = 4'b0010,
      S_PROBE = 4'b0100,
      S_CMP   = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [sool_pkg::CNT_W-1:0]         counts_ff [sool_pkg::NUM_TYPES];
   logic [sool_pkg::CNT_W-1:0]         counts_in [sool_pkg::NUM_TYPES];
   logic [sool_pkg::CNT_W-1:0]         total_ff, total_in;
   logic [sool_pkg::TYPE_W-1:0]        last_ff, last_in;
   logic signed [sool_pkg::ID_W-1:0]   key_ff, key_in;
   logic [sool_pkg::TYPE_W-1:0]        qtype_ff, qtype_in;
   logic [sool_pkg::TYPE_W-1:0]        tidx_ff, tidx_in;
   logic [sool_pkg::CNT_W-1:0]         base_ff, base_in;
   logic signed [sool_pkg::IDX_W-1:0]  left_ff, left_in;
   logic signed [sool_pkg::IDX_W-1:0]  right_ff, right_in;
   logic [sool_pkg::CNT_W-1:0]         mid_ff, mid_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   sool_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [sool_pkg::OFS_W-1:0]         rsp_ofs_ff, rsp_ofs_in;

   logic [sool_pkg::TYPE_W-1:0]        cnt_rd_idx;
   logic [sool_pkg::CNT_W-1:0]         cnt_rd;
   logic [sool_pkg::IDX_W:0]           sum_w;
   logic [sool_pkg::CNT_W-1:0]         mid_w;
   logic [sool_pkg::CNT_W:0]           pos_w;
   logic                               slot_free;

   logic                               wr_en, rd_en;
   logic [sool_pkg::ADDR_W-1:0]        wr_addr, rd_addr;
   logic [sool_pkg::ID_W-1:0]          rd_id;
   logic [sool_pkg::OFS_W-1:0]         rd_ofs;

   sool_ram #(.WIDTH(sool_pkg::ID_W), .DEPTH(sool_pkg::TABLE_DEPTH)) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_id)
   );

   sool_ram #(.WIDTH(sool_pkg::OFS_W), .DEPTH(sool_pkg::TABLE_DEPTH)) u_ofs_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.offset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_ofs)
   );

   // The count table has a single read port, shared by load and base walk.
   assign cnt_rd_idx = (state_ff == S_IDLE) ? cmd.etype : tidx_ff;
   assign cnt_rd     = counts_ff[cnt_rd_idx];

   // Both bounds are non-negative whenever a probe is issued.
   assign sum_w = {1'b0, left_ff} + {1'b0, right_ff};
   assign mid_w = sum_w[sool_pkg::CNT_W:1];
   assign pos_w = {1'b0, base_ff} + {1'b0, mid_w};

   assign slot_free = !rsp_valid_ff || pop;
   assign wr_addr   = total_ff[sool_pkg::ADDR_W-1:0];
   assign rd_addr   = pos_w[sool_pkg::ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      counts_in     = counts_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      key_in        = key_ff;
      qtype_in      = qtype_ff;
      tidx_in       = tidx_ff;
      base_in       = base_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      rsp_valid_in  = rsp_valid_ff && !pop;
      rsp_status_in = rsp_status_ff;
      rsp_ofs_in    = rsp_ofs_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  sool_pkg::OP_CLEAR: begin
                     counts_in     = '{default: '0};
                     total_in      = '0;
                     last_in       = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = sool_pkg::STAT_DONE;
                     rsp_ofs_in    = '0;
                  end
                  sool_pkg::OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_ofs_in   = '0;
                     if (total_ff >= sool_pkg::TOTAL_MAX) begin
                        rsp_status_in = sool_pkg::STAT_FULL;
                     end else if (!cmd.type_ok || (cmd.etype < last_ff)) begin
                        rsp_status_in = sool_pkg::STAT_ORDER;
                     end else begin
                        wr_en                = 1'b1;
                        total_in             = total_ff + sool_pkg::CNT_W'(1);
                        counts_in[cmd.etype] = cnt_rd + sool_pkg::CNT_W'(1);
                        last_in              = cmd.etype;
                        rsp_status_in        = sool_pkg::STAT_DONE;
                     end
                  end
                  sool_pkg::OP_LOOKUP: begin
                     if (cmd.type_ok) begin
                        key_in   = cmd.id;
                        qtype_in = cmd.etype;
                        tidx_in  = '0;
                        base_in  = '0;
                        state_in = S_BASE;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sool_pkg::STAT_NOT_FOUND;
                        rsp_ofs_in    = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = sool_pkg::STAT_DONE;
                     rsp_ofs_in    = '0;
                  end
               endcase
            end
         end
         S_BASE: begin
            if (tidx_ff == qtype_ff) begin
               left_in  = '0;
               right_in = $signed({1'b0, cnt_rd}) - sool_pkg::IDX_W'(1);
               state_in = S_PROBE;
            end else begin
               base_in = base_ff + cnt_rd;
               tidx_in = tidx_ff + sool_pkg::TYPE_W'(1);
            end
         end
         S_PROBE: begin
            if ((left_ff > right_ff) || (pos_w >= sool_pkg::POS_LIMIT)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sool_pkg::STAT_NOT_FOUND;
               rsp_ofs_in    = '0;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               mid_in   = mid_w;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if ($signed(rd_id) == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sool_pkg::STAT_FOUND;
               rsp_ofs_in    = rd_ofs;
               state_in      = S_IDLE;
            end else if ($signed(rd_id) < key_ff) begin
               left_in  = $signed({1'b0, mid_ff}) + sool_pkg::IDX_W'(1);
               state_in = S_PROBE;
            end else begin
               right_in = $signed({1'b0, mid_ff}) - sool_pkg::IDX_W'(1);
               state_in = S_PROBE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         counts_ff    <= '{default: '0};
         total_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         total_ff     <= total_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      qtype_ff      <= qtype_in;
      tidx_ff       <= tidx_in;
      base_ff       <= base_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      mid_ff        <= mid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ofs_ff    <= rsp_ofs_in;
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_offset = rsp_ofs_ff;

   `ASSERT_IMPLY(a_total_bound, clock, reset, 1'b1, total_ff <= sool_pkg::TOTAL_MAX)
   `ASSERT_IMPLY(a_dispatch_slot_free, clock, reset, cmd_pop, !rsp_valid_ff || pop)
   `ASSERT_IMPLY(a_cmp_after_probe, clock, reset, state_ff == S_CMP, $past(state_ff) == S_PROBE)
   `ASSERT_IMPLY(a_no_result_in_search, clock, reset, state_ff == S_PROBE, !rsp_valid_ff)

endmodule

@@ test/sorted_id_offset_lookup_checker.sv @@
`timescale 1ns / 1ps

module sorted_id_offset_lookup_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             full,
   input  logic [sool_pkg::OPC_W-1:0]       req_opcode,
   input  logic [sool_pkg::TYPE_W-1:0]      req_entry_type,
   input  logic signed [sool_pkg::ID_W-1:0] req_entry_id,
   input  logic [sool_pkg::OFS_W-1:0]       req_entry_offset,
   input  logic                             empty,
   input  logic                             pop,
   input  logic [sool_pkg::STAT_W-1:0]      rsp_status,
   input  logic [sool_pkg::OFS_W-1:0]       rsp_found_offset,
   output int                               failures,
   output int                               pending
);
   import sool_pkg::*;

   typedef struct packed {
      status_type       status;
      logic [OFS_W-1:0] offset;
   } reply_t;

   // Shadow copy of the table and its bookkeeping.
   logic signed [ID_W-1:0] shadow_ids [TABLE_DEPTH];
   logic [OFS_W-1:0]       shadow_offsets [TABLE_DEPTH];
   int                     type_count [NUM_TYPES];
   int                     entries;
   int                     newest_type;

   reply_t                 awaited_replies [$];
   int                     mismatches;

   task automatic flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   function automatic void forget_table();
      int t;
      for (t = 0; t < NUM_TYPES; t++) begin
         type_count[t] = 0;
      end
      entries     = 0;
      newest_type = 0;
   endfunction

   // Applies one command to the shadow table and returns the reply it earns.
   function automatic reply_t apply_command(opcode_type op, logic [TYPE_W-1:0] etype,
                                            logic signed [ID_W-1:0] id,
                                            logic [OFS_W-1:0] ofs);
      reply_t r;
      int     t, base, lo, hi, mid, pos;
      r.status = STAT_DONE;
      r.offset = '0;
      case (op)
         OP_CLEAR: begin
            forget_table();
         end
         OP_LOAD: begin
            if (entries >= TABLE_DEPTH) begin
               r.status = STAT_FULL;
            end else if (int'(etype) >= NUM_TYPES || int'(etype) < newest_type) begin
               r.status = STAT_ORDER;
            end else begin
               shadow_ids[entries]     = id;
               shadow_offsets[entries] = ofs;
               entries++;
               type_count[etype]++;
               newest_type = int'(etype);
            end
         end
         OP_LOOKUP: begin
            r.status = STAT_NOT_FOUND;
            if (int'(etype) < NUM_TYPES) begin
               base = 0;
               for (t = 0; t < int'(etype); t++) begin
                  base += type_count[t];
               end
               lo = 0;
               hi = type_count[etype] - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  pos = base + mid;
                  if (pos >= TABLE_DEPTH) begin
                     break;
                  end
                  if (shadow_ids[pos] < id) begin
                     lo = mid + 1;
                  end else if (shadow_ids[pos] > id) begin
                     hi = mid - 1;
                  end else begin
                     r.status = STAT_FOUND;
                     r.offset = shadow_offsets[pos];
                     break;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_t want;
      if (reset) begin
         forget_table();
         awaited_replies.delete();
         mismatches = 0;
      end else begin
         // Results are matched before the new request is predicted.
         if (pop && !empty) begin
            if (awaited_replies.size() == 0) begin
               flag($sformatf("unexpected word: status %0d offset 0x%h",
                              rsp_status, rsp_found_offset));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status) begin
                  flag($sformatf("status mismatch: expected %0d, actual %0d",
                                 want.status, rsp_status));
               end
               if (rsp_found_offset !== want.offset) begin
                  flag($sformatf("offset mismatch: expected 0x%h, actual 0x%h",
                                 want.offset, rsp_found_offset));
               end
            end
         end
         if (push && !full) begin
            awaited_replies.push_back(apply_command(opcode_type'(req_opcode), req_entry_type,
                                                    req_entry_id, req_entry_offset));
         end
      end
      failures <= mismatches;
      pending  <= awaited_replies.size();
   end

endmodule

@@ test/tb_sorted_id_offset_lookup.sv @@
`timescale 1ns / 1ps

module tb_sorted_id_offset_lookup;
   import sool_pkg::*;

   // Cycles with no accepted word before the run is declared hung. The slowest
   // legal gap is the long receiver hold below plus a few deep lookups.
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_WORDS = 1150;
   localparam int DRAIN_CYCLES = 60;

   localparam logic signed [ID_W-1:0] ID_MIN  = {1'b1, {(ID_W-1){1'b0}}};
   localparam logic signed [ID_W-1:0] ID_MAX  = {1'b0, {(ID_W-1){1'b1}}};
   localparam logic [OFS_W-1:0]       OFS_MAX = '1;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   push             = 1'b0;
   logic                   pop              = 1'b0;
   logic [OPC_W-1:0]       req_opcode       = '0;
   logic [TYPE_W-1:0]      req_entry_type   = '0;
   logic signed [ID_W-1:0] req_entry_id     = '0;
   logic [OFS_W-1:0]       req_entry_offset = '0;
   logic                   full;
   logic                   empty;
   logic [STAT_W-1:0]      rsp_status;
   logic [OFS_W-1:0]       rsp_found_offset;

   int                     failures;
   int                     pending;

   // Shared knobs: calm switches idling off on both sides, hold_armed asks the
   // receiver for one long hold-off so that the block backs up.
   logic                   calm       = 1'b0;
   logic                   hold_armed = 1'b0;
   logic                   hold_taken = 1'b0;
   int                     hold_left  = 0;
   int                     quiet_cycles = 0;

   int                     words_sent = 0;
   logic signed [ID_W-1:0] loaded_ids [$];
   int                     loaded_types [$];

   always #4 clock = ~clock;

   sorted_id_offset_lookup i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_entry_type   (req_entry_type),
      .req_entry_id     (req_entry_id),
      .req_entry_offset (req_entry_offset),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_found_offset (rsp_found_offset)
   );

   sorted_id_offset_lookup_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_entry_type   (req_entry_type),
      .req_entry_id     (req_entry_id),
      .req_entry_offset (req_entry_offset),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_found_offset (rsp_found_offset),
      .failures         (failures),
      .pending          (pending)
   );

   // The receiver pops at random, except during calm stretches and during the
   // single long hold, which it times in its own counter.
   always @(posedge clock) begin
      if (reset) begin
         pop        <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         pop        <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= calm || ($urandom_range(0, 99) >= 28);
      end
   end

   // Watchdog: any accepted word on either side proves progress.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("sorted_id_offset_lookup verification failed");
            $finish;
         end
      end
   end

   // Identifiers lean on the signed extremes and on zero and minus one.
   function automatic logic signed [ID_W-1:0] rand_id();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return ID_MIN;
         1:       return ID_MAX;
         2:       return '0;
         3:       return '1;
         default: return $signed(r);
      endcase
   endfunction

   function automatic logic [OFS_W-1:0] rand_ofs();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return OFS_MAX;
         default: return r[OFS_W-1:0];
      endcase
   endfunction

   // Offers one word and returns at the edge where it is taken. The sender may
   // idle first; push only drops during such an idle cycle, never between two
   // back-to-back words.
   task automatic send(opcode_type op, int etype, logic signed [ID_W-1:0] id,
                       logic [OFS_W-1:0] ofs);
      while (!calm && $urandom_range(0, 99) < 28) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_opcode       <= op;
      req_entry_type   <= etype[TYPE_W-1:0];
      req_entry_id     <= id;
      req_entry_offset <= ofs;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // Lookups mostly aim at identifiers that were loaded, their neighbors, or
   // the right key under the wrong type; a few are fully random. Now and then a
   // stray load lands between them and may be refused as out of order.
   task automatic probe_table(int count);
      int                     pick, i;
      logic signed [ID_W-1:0] key;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (loaded_ids.size() == 0 || pick == 0) begin
            send(OP_LOOKUP, $urandom_range(0, 7), rand_id(), rand_ofs());
         end else begin
            i   = $urandom_range(0, loaded_ids.size() - 1);
            key = loaded_ids[i];
            if (pick == 7) begin
               key = key + 1;
            end else if (pick == 8) begin
               key = key - 1;
            end
            send(OP_LOOKUP, (pick == 9) ? $urandom_range(0, 7) : loaded_types[i], key,
                 rand_ofs());
         end
         if ($urandom_range(0, 24) == 0) begin
            send(OP_LOAD, $urandom_range(0, 7), rand_id(), rand_ofs());
         end
      end
   endtask

   // A well-formed session: clear, then regions of ascending type, each sorted
   // by identifier, then a burst of lookups. Dense regions step by 0 to 3 so
   // that duplicates appear; sparse ones stride widely across the signed range.
   task automatic tidy_session(int max_per_type);
      int                     t, n, k, start_mode;
      logic                   dense;
      logic [63:0]            r;
      logic signed [ID_W-1:0] cur, step;
      loaded_ids.delete();
      loaded_types.delete();
      send(OP_CLEAR, $urandom_range(0, 7), rand_id(), rand_ofs());
      for (t = $urandom_range(0, 2); t < NUM_TYPES; t += $urandom_range(1, 3)) begin
         n          = $urandom_range(0, max_per_type);
         dense      = $urandom_range(0, 1);
         start_mode = $urandom_range(0, 3);
         case (start_mode)
            0:       cur = ID_MIN + $urandom_range(0, 3);
            1:       cur = ID_MAX - $urandom_range(0, 40);
            default: cur = rand_id();
         endcase
         for (k = 0; k < n; k++) begin
            if (k > 0) begin
               r    = {$urandom, $urandom};
               step = dense ? $urandom_range(0, 3) : $signed(r >> $urandom_range(2, 62));
               if (cur > ID_MAX - step) begin
                  break;
               end
               cur = cur + step;
            end
            send(OP_LOAD, t, cur, rand_ofs());
            loaded_ids.push_back(cur);
            loaded_types.push_back(t);
            if ($urandom_range(0, 19) == 0) begin
               send(OP_NONE, $urandom_range(0, 7), rand_id(), rand_ofs());
            end
         end
      end
      probe_table(loaded_ids.size() + $urandom_range(2, 6));
   endtask

   // Raw commands with no structure: any opcode, type and field values, and no
   // clear first, so loads can land unsorted or out of type order.
   task automatic noise_session();
      repeat ($urandom_range(8, 30)) begin
         send(opcode_type'($urandom_range(0, 3)), $urandom_range(0, 7), rand_id(),
              rand_ofs());
      end
   endtask

   initial begin : stimulus
      int session;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. An empty table, the unused opcode, the identifier
      // and offset extremes, a duplicate, a refused lower type, then lookups
      // that hit, fall above or below a region, or land on an empty type.
      send(OP_LOOKUP, 0, '0, '0);
      send(OP_NONE, 5, ID_MAX, OFS_MAX);
      send(OP_LOAD, 0, ID_MIN, '0);
      send(OP_LOAD, 0, '1, OFS_MAX);
      send(OP_LOAD, 0, '0, 48'd1);
      send(OP_LOAD, 2, ID_MAX, OFS_MAX);
      send(OP_LOAD, 2, ID_MAX, 48'd5);
      send(OP_LOAD, 1, 64'sd7, 48'd9);
      send(OP_LOAD, 7, '0, 48'h1234_5678_9ABC);
      send(OP_LOOKUP, 0, ID_MIN, '0);
      send(OP_LOOKUP, 0, '1, '0);
      send(OP_LOOKUP, 0, '0, '0);
      send(OP_LOOKUP, 0, 64'sd1, '0);
      send(OP_LOOKUP, 2, ID_MAX, '0);
      send(OP_LOOKUP, 2, '0, '0);
      send(OP_LOOKUP, 1, '0, '0);
      send(OP_LOOKUP, 7, '0, OFS_MAX);
      send(OP_LOOKUP, 7, ID_MIN, '0);
      // Clear keeps the stored words but forgets them.
      send(OP_CLEAR, 3, '1, OFS_MAX);
      send(OP_LOOKUP, 0, ID_MIN, '0);
      send(OP_LOAD, 5, 64'sd42, 48'd77);
      send(OP_LOOKUP, 5, 64'sd42, '0);

      // Random part. Session 2 carries the long receiver hold, and sessions
      // 6 to 10 run with no idling at all.
      words_sent = 0;
      session    = 0;
      while (words_sent < RANDOM_WORDS) begin
         calm <= (session >= 6 && session <= 10);
         if (session == 2) begin
            hold_armed <= 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            tidy_session(($urandom_range(0, 7) == 0) ? 60 : 12);
         end else begin
            noise_session();
         end
         session++;
      end

      // Drain: wait for every expected word, then a little longer in case
      // the block sends anything it should not.
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("sorted_id_offset_lookup verification clean");
      end else begin
         $display("sorted_id_offset_lookup verification failed");
      end
      $finish;
   end

endmodule
